// ===== rtl/afrd_pkg.sv =====
// Shared types, constants and pattern tables for the AT final result detector.
package afrd_pkg;

	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	localparam int unsigned COL_W = 4;
	localparam logic [COL_W-1:0] COL_MAX = 4'd15;

	localparam logic [7:0] BYTE_LF = 8'h0A;
	localparam logic [7:0] BYTE_CR = 8'h0D;

	localparam int unsigned PAT_COUNT  = 8;
	localparam int unsigned PAT_EXACT  = 6;
	localparam int unsigned PAT_MAXLEN = 11;
	localparam int unsigned PAT_IDX_W  = $clog2(PAT_COUNT);

	// result kind codes
	localparam logic [3:0] KIND_NONE     = 4'd0;
	localparam logic [3:0] KIND_OK       = 4'd1;
	localparam logic [3:0] KIND_ERROR    = 4'd2;
	localparam logic [3:0] KIND_BUSY     = 4'd3;
	localparam logic [3:0] KIND_NOANSWER = 4'd4;
	localparam logic [3:0] KIND_NOCARR   = 4'd5;
	localparam logic [3:0] KIND_NODIAL   = 4'd6;
	localparam logic [3:0] KIND_CME      = 4'd7;
	localparam logic [3:0] KIND_CMS      = 4'd8;

	// prefix seen codes
	localparam logic [1:0] PFX_NONE = 2'd0;
	localparam logic [1:0] PFX_CME  = 2'd1;
	localparam logic [1:0] PFX_CMS  = 2'd2;

	localparam int unsigned PAT_CME = 6;
	localparam int unsigned PAT_CMS = 7;

	localparam logic [COL_W-1:0] PAT_LEN [PAT_COUNT] = '{
		4'd2, 4'd5, 4'd4, 4'd9, 4'd10, 4'd11, 4'd11, 4'd11
	};

	localparam logic [7:0] PAT_TEXT [PAT_COUNT][PAT_MAXLEN] = '{
		'{"O", "K", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"E", "R", "R", "O", "R", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"B", "U", "S", "Y", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"N", "O", " ", "A", "N", "S", "W", "E", "R", 8'h00, 8'h00},
		'{"N", "O", " ", "C", "A", "R", "R", "I", "E", "R", 8'h00},
		'{"N", "O", " ", "D", "I", "A", "L", "T", "O", "N", "E"},
		'{"+", "C", "M", "E", " ", "E", "R", "R", "O", "R", ":"},
		'{"+", "C", "M", "S", " ", "E", "R", "R", "O", "R", ":"}
	};

	// one queued byte, already classified
	typedef struct packed {
		logic [7:0] data;
		logic       is_lf;
	} item_t;

	// character of pattern idx at column col; NUL past the longest pattern
	function automatic logic [7:0] pat_char(input logic [PAT_IDX_W-1:0] idx,
	                                        input logic [COL_W-1:0] col);
		logic [7:0] ch;
		ch = 8'h00;
		if (col < COL_W'(PAT_MAXLEN)) begin
			ch = PAT_TEXT[idx][col];
		end
		return ch;
	endfunction

endpackage

// ===== rtl/at_final_result_detector.sv =====
// Top level of the AT final result detector.
// Takes one modem response byte per cycle on resp_* and gives one result per byte that is
// not a carriage return on result_* (carriage returns are taken and dropped). A line feed
// result carries line_end and, when the line just ended is OK, ERROR, BUSY, NO ANSWER,
// NO CARRIER, NO DIALTONE or begins with +CME ERROR: / +CMS ERROR:, final_result and its
// result_kind. Sustained rate is one byte per cycle while result_stall is low; a byte passes
// through the four-entry queue between the input decode and the registered line matcher,
// then through the result register, before it reaches the output. The input stalls only
// when that queue is full.
module at_final_result_detector (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       resp_valid,
	output logic       resp_stall,
	input  logic [7:0] resp_byte,
	output logic       result_valid,
	input  logic       result_stall,
	output logic [7:0] out_byte,
	output logic       line_end,
	output logic       final_result,
	output logic [3:0] result_kind
);

	logic             q_full;
	logic             q_push;
	logic             q_pop;
	logic             q_nonempty;
	afrd_pkg::item_t  push_item;
	afrd_pkg::item_t  pop_item;

	afrd_front u_front (
		.resp_valid (resp_valid),
		.resp_byte  (resp_byte),
		.resp_stall (resp_stall),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_item     (push_item)
	);

	afrd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.nonempty  (q_nonempty),
		.pop_item  (pop_item)
	);

	afrd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_nonempty   (q_nonempty),
		.q_item       (pop_item),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.out_byte     (out_byte),
		.line_end     (line_end),
		.final_result (final_result),
		.result_kind  (result_kind)
	);

endmodule

// ===== rtl/afrd_front.sv =====
// Front end: takes response bytes, drops carriage returns, tags line feeds.
module afrd_front (
	input  logic             resp_valid,
	input  logic [7:0]       resp_byte,
	output logic             resp_stall,
	input  logic             q_full,
	output logic             q_push,
	output afrd_pkg::item_t  q_item
);

	logic is_cr;

	assign is_cr       = (resp_byte == afrd_pkg::BYTE_CR);
	assign resp_stall  = q_full;
	// a CR transfer is taken but never queued
	assign q_push       = resp_valid && !q_full && !is_cr;
	assign q_item.data  = resp_byte;
	assign q_item.is_lf = (resp_byte == afrd_pkg::BYTE_LF);

endmodule

// ===== rtl/afrd_queue.sv =====
// Short FIFO between the front end and the line matcher.
module afrd_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  afrd_pkg::item_t  push_item,
	output logic             full,
	input  logic             pop,
	output logic             nonempty,
	output afrd_pkg::item_t  pop_item
);

	afrd_pkg::item_t                    mem_q [afrd_pkg::QDEPTH];
	logic [afrd_pkg::QPTR_W-1:0]        wr_ptr_q;
	logic [afrd_pkg::QPTR_W-1:0]        rd_ptr_q;
	logic [afrd_pkg::QCNT_W-1:0]        count_q;
	logic                               do_push;
	logic                               do_pop;

	assign full     = (count_q == afrd_pkg::QCNT_W'(afrd_pkg::QDEPTH));
	assign nonempty = (count_q != '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && nonempty;
	assign pop_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= afrd_pkg::QCNT_W'(afrd_pkg::QDEPTH))
		else $error("queue count beyond depth");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_ptr_q - rd_ptr_q) == count_q[afrd_pkg::QPTR_W-1:0])
		else $error("queue pointers disagree with count");

	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(!nonempty && !do_push) |=> !nonempty)
		else $error("queue became non-empty without a push");

endmodule

// ===== rtl/afrd_back.sv =====
// Back end: line matcher state, classification at line feed, result register.
module afrd_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_nonempty,
	input  afrd_pkg::item_t  q_item,
	output logic             q_pop,
	output logic             result_valid,
	input  logic             result_stall,
	output logic [7:0]       out_byte,
	output logic             line_end,
	output logic             final_result,
	output logic [3:0]       result_kind
);

	logic [afrd_pkg::COL_W-1:0]     column_q;
	logic [afrd_pkg::PAT_COUNT-1:0] cand_q;
	logic [1:0]                     pfx_q;

	logic                           valid_q;
	logic [7:0]                     byte_q;
	logic                           lf_q;
	logic [3:0]                     kind_q;

	logic                           load;
	logic [afrd_pkg::PAT_COUNT-1:0] keep;
	logic [1:0]                     pfx_nxt;
	logic [3:0]                     kind;

	assign load  = !valid_q || !result_stall;
	assign q_pop = q_nonempty && load;

	// advance all candidates by one byte
	always_comb begin
		keep    = '0;
		pfx_nxt = pfx_q;
		for (int i = 0; i < afrd_pkg::PAT_COUNT; i++) begin
			if (cand_q[i] && (column_q < afrd_pkg::PAT_LEN[i]) &&
			    (afrd_pkg::pat_char(afrd_pkg::PAT_IDX_W'(i), column_q) == q_item.data)) begin
				keep[i] = 1'b1;
				if ((i >= afrd_pkg::PAT_CME) && (pfx_nxt == afrd_pkg::PFX_NONE) &&
				    (({1'b0, column_q} + 1'b1) == {1'b0, afrd_pkg::PAT_LEN[i]})) begin
					pfx_nxt = (i == afrd_pkg::PAT_CME) ? afrd_pkg::PFX_CME
					                                   : afrd_pkg::PFX_CMS;
				end
			end
		end
	end

	// classify the finished line; lowest pattern index wins
	always_comb begin
		kind = afrd_pkg::KIND_NONE;
		for (int i = afrd_pkg::PAT_EXACT - 1; i >= 0; i--) begin
			if (cand_q[i] && (column_q == afrd_pkg::PAT_LEN[i])) begin
				kind = 4'(i + 1);
			end
		end
		if (pfx_q == afrd_pkg::PFX_CME) begin
			kind = afrd_pkg::KIND_CME;
		end else if (pfx_q == afrd_pkg::PFX_CMS) begin
			kind = afrd_pkg::KIND_CMS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			cand_q   <= '1;
			pfx_q    <= afrd_pkg::PFX_NONE;
			valid_q  <= 1'b0;
		end else begin
			if (q_pop) begin
				if (q_item.is_lf) begin
					column_q <= '0;
					cand_q   <= '1;
					pfx_q    <= afrd_pkg::PFX_NONE;
				end else begin
					cand_q <= keep;
					pfx_q  <= pfx_nxt;
					if (column_q != afrd_pkg::COL_MAX) begin
						column_q <= column_q + 1'b1;
					end
				end
			end
			if (load) begin
				valid_q <= q_nonempty;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			byte_q <= q_item.data;
			lf_q   <= q_item.is_lf;
			kind_q <= q_item.is_lf ? kind : afrd_pkg::KIND_NONE;
		end
	end

	assign result_valid = valid_q;
	assign out_byte     = byte_q;
	assign line_end     = lf_q;
	assign result_kind  = kind_q;
	assign final_result = (kind_q != afrd_pkg::KIND_NONE);

	a_mid_line_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !lf_q) |-> (kind_q == afrd_pkg::KIND_NONE))
		else $error("result kind set on a byte that does not end a line");

	a_no_cr_out: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (byte_q != afrd_pkg::BYTE_CR))
		else $error("carriage return reached the output");

	a_lf_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && q_item.is_lf) |=> ((column_q == '0) && (cand_q == '1) &&
		                             (pfx_q == afrd_pkg::PFX_NONE)))
		else $error("line state not cleared after line feed");

	a_prefix_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(pfx_q != afrd_pkg::PFX_NONE && !(q_pop && q_item.is_lf)) |=> $stable(pfx_q))
		else $error("prefix mark changed within a line");

endmodule
